FILE: rtl/bbtg_pkg.sv
`default_nettype none

package bbtg_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = 2 ** ADDR_W;
    localparam int DIM_W    = 9;
    localparam int CNT_W    = 17;
    localparam int NBR_W    = 4;
    localparam int PHASE_W  = 4;

    localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [PHASE_W-1:0] PHASE_CENTER = PHASE_W'(8);
    localparam logic [PHASE_W-1:0] PHASE_LAST   = PHASE_W'(9);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(100);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(90);

    localparam logic [1:0] CELL_OFF   = 2'd0;
    localparam logic [1:0] CELL_DYING = 2'd1;
    localparam logic [1:0] CELL_ON    = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic              rd_buf;
        logic [ADDR_W-1:0] rd_addr;
        logic              we;
        logic              wr_both;
        logic              wr_buf;
        logic [ADDR_W-1:0] wr_addr;
        logic [1:0]        wr_data;
    } t_store_req;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic logic [1:0] next_state(input logic [1:0] v,
                                              input logic [NBR_W-1:0] n);
        logic [1:0] r;
        unique case (v)
            CELL_OFF: r = (n == NBR_W'(2)) ? CELL_ON : CELL_OFF;
            CELL_ON:  r = CELL_DYING;
            default:  r = CELL_OFF;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bbtg_if.sv
`default_nettype none

interface bbtg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [1:0] cell_value;
    modport source(output valid, opcode, cell_col, cell_row, cell_value, input ready);
    modport sink(input valid, opcode, cell_col, cell_row, cell_value, output ready);
endinterface

interface bbtg_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cell_state;
    logic [16:0] changed_count;
    logic        range_error;
    modport source(output valid, cell_state, changed_count, range_error, input ready);
    modport sink(input valid, cell_state, changed_count, range_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/brians_brain_toroidal_grid_core.sv
// Brian's Brain automaton on a torus, two generation buffers in block memory.
// i_cmd carries one command per transaction (write cell, step, read cell,
// clear); o_res returns exactly one result transaction per command.
// i_cfg_we/i_cfg_idx/i_cfg_data write grid width (index 0) and height
// (index 1); write them only while no command is in flight.
// A step visits each cell once: nine reads through the single read port of
// the store (eight neighbors and the cell), then the write of the new state
// into the other buffer. Clear writes one address of both buffers per cycle.
// One command is in work at a time. A result sits in an output register; a
// new command is accepted while it waits, and that command finishes its work
// and then holds until the receiver takes the pending result.
// Reset is synchronous and active low. After reset the core runs a clearing
// pass over the store with i_cmd.ready low; configuration writes are taken
// throughout.
`default_nettype none

module brians_brain_toroidal_grid_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bbtg_in_if.sink                          i_cmd,
    bbtg_out_if.source                       o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [bbtg_pkg::DIM_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ACCESS,
        S_RDATA,
        S_STEP,
        S_CLEAR,
        S_RESULT
    } t_state;

    t_state                           r_state;
    logic                             r_cur;
    logic [bbtg_pkg::ADDR_W-1:0]      r_addr;
    logic [bbtg_pkg::DIM_W-1:0]       r_w;
    logic [bbtg_pkg::DIM_W-1:0]       r_h;
    bbtg_pkg::t_op                    r_op;
    logic [bbtg_pkg::COL_W-1:0]       r_col;
    logic [bbtg_pkg::ROW_W-1:0]       r_row;
    logic [1:0]                       r_val;
    logic                             r_err;
    logic [bbtg_pkg::COL_W-1:0]       r_c;
    logic [bbtg_pkg::ROW_W-1:0]       r_r;
    logic [bbtg_pkg::PHASE_W-1:0]     r_k;
    logic [bbtg_pkg::NBR_W-1:0]       r_n;
    logic [bbtg_pkg::CNT_W-1:0]       r_count;
    logic [1:0]                       r_res_state;
    logic [bbtg_pkg::CNT_W-1:0]       r_res_count;
    logic                             r_res_err;
    logic                             r_ovalid;
    logic [1:0]                       r_ostate;
    logic [bbtg_pkg::CNT_W-1:0]       r_ocount;
    logic                             r_oerr;

    logic [bbtg_pkg::DIM_W-1:0]       w_eff;
    logic [bbtg_pkg::DIM_W-1:0]       h_eff;
    logic [bbtg_pkg::COL_W-1:0]       last_c;
    logic [bbtg_pkg::ROW_W-1:0]       last_r;
    logic [bbtg_pkg::COL_W-1:0]       cw;
    logic [bbtg_pkg::COL_W-1:0]       ce;
    logic [bbtg_pkg::ROW_W-1:0]       rn;
    logic [bbtg_pkg::ROW_W-1:0]       rs;
    logic [bbtg_pkg::COL_W-1:0]       nb_c;
    logic [bbtg_pkg::ROW_W-1:0]       nb_r;
    logic [1:0]                       rdata;
    logic [1:0]                       nv;
    logic                             in_err;
    logic                             accept;
    logic                             at_end;
    bbtg_pkg::t_store_req             req;
    logic [bbtg_pkg::CNT_W-1:0]       n_count;

    assign w_eff  = bbtg_pkg::eff_dim(r_w, bbtg_pkg::DIM_W'(bbtg_pkg::MAX_COLS));
    assign h_eff  = bbtg_pkg::eff_dim(r_h, bbtg_pkg::DIM_W'(bbtg_pkg::MAX_ROWS));
    assign last_c = bbtg_pkg::COL_W'(w_eff - bbtg_pkg::DIM_W'(1));
    assign last_r = bbtg_pkg::ROW_W'(h_eff - bbtg_pkg::DIM_W'(1));
    assign cw     = (r_c == '0) ? last_c : r_c - bbtg_pkg::COL_W'(1);
    assign ce     = (r_c == last_c) ? '0 : r_c + bbtg_pkg::COL_W'(1);
    assign rn     = (r_r == '0) ? last_r : r_r - bbtg_pkg::ROW_W'(1);
    assign rs     = (r_r == last_r) ? '0 : r_r + bbtg_pkg::ROW_W'(1);
    assign at_end = (r_c == last_c) && (r_r == last_r);

    always_comb begin
        unique case (r_k)
            bbtg_pkg::PHASE_W'(0): begin nb_c = ce;  nb_r = r_r; end
            bbtg_pkg::PHASE_W'(1): begin nb_c = ce;  nb_r = rs;  end
            bbtg_pkg::PHASE_W'(2): begin nb_c = r_c; nb_r = rs;  end
            bbtg_pkg::PHASE_W'(3): begin nb_c = cw;  nb_r = rs;  end
            bbtg_pkg::PHASE_W'(4): begin nb_c = cw;  nb_r = r_r; end
            bbtg_pkg::PHASE_W'(5): begin nb_c = cw;  nb_r = rn;  end
            bbtg_pkg::PHASE_W'(6): begin nb_c = r_c; nb_r = rn;  end
            bbtg_pkg::PHASE_W'(7): begin nb_c = ce;  nb_r = rn;  end
            default:               begin nb_c = r_c; nb_r = r_r; end
        endcase
    end

    assign in_err = ({1'b0, i_cmd.cell_col} >= w_eff) || ({1'b0, i_cmd.cell_row} >= h_eff);
    assign accept = i_cmd.valid && i_cmd.ready;
    assign nv     = bbtg_pkg::next_state(rdata, r_n);
    assign n_count = ((nv != rdata) && (r_count != bbtg_pkg::CNT_MAX))
                     ? r_count + bbtg_pkg::CNT_W'(1) : r_count;

    always_comb begin
        req         = '0;
        req.rd_buf  = r_cur;
        req.rd_addr = (r_state == S_STEP) ? {nb_r, nb_c} : {r_row, r_col};
        req.wr_buf  = r_cur;
        req.wr_addr = {r_row, r_col};
        req.wr_data = (r_val > bbtg_pkg::CELL_ON) ? bbtg_pkg::CELL_ON : r_val;
        unique case (r_state)
            S_ACCESS: begin
                req.we = (r_op == bbtg_pkg::OP_WRITE) && !r_err;
            end
            S_STEP: begin
                req.we      = (r_k == bbtg_pkg::PHASE_LAST);
                req.wr_buf  = ~r_cur;
                req.wr_addr = {r_r, r_c};
                req.wr_data = nv;
            end
            S_INIT, S_CLEAR: begin
                req.we      = 1'b1;
                req.wr_both = 1'b1;
                req.wr_addr = r_addr;
                req.wr_data = bbtg_pkg::CELL_OFF;
            end
            default: begin
                req.we = 1'b0;
            end
        endcase
    end

    bbtg_store u_store (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_cur    <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            r_w      <= bbtg_pkg::WIDTH_RESET;
            r_h      <= bbtg_pkg::HEIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bbtg_pkg::CFG_WIDTH:  r_w <= i_cfg_data;
                    bbtg_pkg::CFG_HEIGHT: r_h <= i_cfg_data;
                    default:              r_w <= r_w;
                endcase
            end
            if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + bbtg_pkg::ADDR_W'(1);
                    if (r_addr == {bbtg_pkg::ADDR_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= bbtg_pkg::t_op'(i_cmd.opcode);
                        r_col   <= i_cmd.cell_col;
                        r_row   <= i_cmd.cell_row;
                        r_val   <= i_cmd.cell_value;
                        r_err   <= in_err;
                        r_c     <= '0;
                        r_r     <= '0;
                        r_k     <= '0;
                        r_n     <= '0;
                        r_count <= '0;
                        r_addr  <= '0;
                        unique case (bbtg_pkg::t_op'(i_cmd.opcode))
                            bbtg_pkg::OP_STEP:  r_state <= S_STEP;
                            bbtg_pkg::OP_CLEAR: r_state <= S_CLEAR;
                            default:            r_state <= S_ACCESS;
                        endcase
                    end
                end
                S_ACCESS: begin
                    if (r_op == bbtg_pkg::OP_READ) begin
                        r_state <= S_RDATA;
                    end else begin
                        r_res_state <= bbtg_pkg::CELL_OFF;
                        r_res_count <= '0;
                        r_res_err   <= r_err;
                        r_state     <= S_RESULT;
                    end
                end
                S_RDATA: begin
                    r_res_state <= r_err ? bbtg_pkg::CELL_OFF : rdata;
                    r_res_count <= '0;
                    r_res_err   <= r_err;
                    r_state     <= S_RESULT;
                end
                S_STEP: begin
                    if (r_k == bbtg_pkg::PHASE_LAST) begin
                        r_k     <= '0;
                        r_n     <= '0;
                        r_count <= n_count;
                        if (r_c == last_c) begin
                            r_c <= '0;
                            r_r <= r_r + bbtg_pkg::ROW_W'(1);
                        end else begin
                            r_c <= r_c + bbtg_pkg::COL_W'(1);
                        end
                        if (at_end) begin
                            r_cur       <= ~r_cur;
                            r_res_state <= bbtg_pkg::CELL_OFF;
                            r_res_count <= n_count;
                            r_res_err   <= 1'b0;
                            r_state     <= S_RESULT;
                        end
                    end else begin
                        r_k <= r_k + bbtg_pkg::PHASE_W'(1);
                        if (r_k == '0) begin
                            r_n <= '0;
                        end else begin
                            r_n <= r_n + bbtg_pkg::NBR_W'(rdata == bbtg_pkg::CELL_ON);
                        end
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + bbtg_pkg::ADDR_W'(1);
                    if (r_addr == {bbtg_pkg::ADDR_W{1'b1}}) begin
                        r_res_state <= bbtg_pkg::CELL_OFF;
                        r_res_count <= '0;
                        r_res_err   <= 1'b0;
                        r_state     <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_ostate <= r_res_state;
                        r_ocount <= r_res_count;
                        r_oerr   <= r_res_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.cell_state    = r_ostate;
    assign o_res.changed_count = r_ocount;
    assign o_res.range_error   = r_oerr;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= bbtg_pkg::PHASE_LAST)
        else $error("step phase out of range");

    a_count_only_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.changed_count != '0))
            |-> (o_res.cell_state == bbtg_pkg::CELL_OFF) && !o_res.range_error)
        else $error("nonzero change count on a non-step result");

    a_swap_at_step_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != $past(r_cur)) |-> ($past(r_state) == S_STEP) && (r_state == S_RESULT))
        else $error("buffer swap outside step completion");
`endif

endmodule

`default_nettype wire

FILE: rtl/bbtg_store.sv
`default_nettype none

module bbtg_store (
    input  wire logic                i_clk,
    input  wire bbtg_pkg::t_store_req i_req,
    output logic [1:0]               o_rdata
);

    logic [1:0] r_mem0 [0:bbtg_pkg::DEPTH-1];
    logic [1:0] r_mem1 [0:bbtg_pkg::DEPTH-1];
    logic [1:0] r_q0;
    logic [1:0] r_q1;
    logic       r_sel;

    always_ff @(posedge i_clk) begin
        if (i_req.we && (i_req.wr_both || !i_req.wr_buf)) begin
            r_mem0[i_req.wr_addr] <= i_req.wr_data;
        end
        r_q0 <= r_mem0[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we && (i_req.wr_both || i_req.wr_buf)) begin
            r_mem1[i_req.wr_addr] <= i_req.wr_data;
        end
        r_q1 <= r_mem1[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_sel <= i_req.rd_buf;
    end

    assign o_rdata = r_sel ? r_q1 : r_q0;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bbtg_pkg::*;

    localparam int LIMIT = 400000;
    localparam int NCELL = MAX_COLS * MAX_ROWS;

    typedef struct packed {
        logic [1:0]  state;
        logic [16:0] count;
        logic        err;
    } t_grid_res;

    typedef struct packed {
        t_op        op;
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] val;
        logic       chk;
        t_grid_res  res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [DIM_W-1:0] i_cfg_data;

    bbtg_in_if  cmd();
    bbtg_out_if res();

    brians_brain_toroidal_grid_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [1:0]       grid [2][NCELL];
    logic             cur_gen;
    logic [DIM_W-1:0] cols_reg;
    logic [DIM_W-1:0] rows_reg;
    t_grid_res        pending_res[$];

    int tx_idle;
    int rx_idle;
    int stall_req;
    int stall_seen;
    int stall_left;
    int fails;
    int n_cmds;
    int n_res;
    int n_steps;
    int n_clears;
    int n_oor;
    int quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic int unsigned on_at(input int unsigned c, input int unsigned r);
        return (grid[cur_gen][r * MAX_COLS + c] == CELL_ON) ? 1 : 0;
    endfunction

    function automatic int unsigned advance_generation();
        int unsigned w, h, cnt, r, c, rn, rs, cw, ce, n, idx;
        logic [1:0] old, nv;
        w = clamp_dim(cols_reg, MAX_COLS);
        h = clamp_dim(rows_reg, MAX_ROWS);
        cnt = 0;
        for (r = 0; r < h; r++) begin
            rn = (r == 0) ? h - 1 : r - 1;
            rs = (r + 1) % h;
            for (c = 0; c < w; c++) begin
                cw = (c == 0) ? w - 1 : c - 1;
                ce = (c + 1) % w;
                n = on_at(ce, r) + on_at(ce, rs) + on_at(c, rs) + on_at(cw, rs)
                  + on_at(cw, r) + on_at(cw, rn) + on_at(c, rn) + on_at(ce, rn);
                idx = r * MAX_COLS + c;
                old = grid[cur_gen][idx];
                if (old == CELL_OFF) nv = (n == 2) ? CELL_ON : CELL_OFF;
                else if (old == CELL_ON) nv = CELL_DYING;
                else nv = CELL_OFF;
                grid[!cur_gen][idx] = nv;
                if (nv != old && cnt < CNT_MAX) cnt++;
            end
        end
        cur_gen = !cur_gen;
        return cnt;
    endfunction

    function automatic t_grid_res apply_cmd(input t_op op, input logic [7:0] col,
                                           input logic [7:0] row, input logic [1:0] val);
        t_grid_res o;
        int unsigned idx;
        o = '0;
        idx = row * MAX_COLS + col;
        case (op)
            OP_WRITE, OP_READ: begin
                if (col >= clamp_dim(cols_reg, MAX_COLS) || row >= clamp_dim(rows_reg, MAX_ROWS)) begin
                    o.err = 1'b1;
                    n_oor++;
                end else if (op == OP_WRITE) begin
                    grid[cur_gen][idx] = (val > CELL_ON) ? CELL_ON : val;
                end else begin
                    o.state = grid[cur_gen][idx];
                end
            end
            OP_STEP: begin
                o.count = 17'(advance_generation());
                n_steps++;
            end
            default: begin
                for (int i = 0; i < NCELL; i++) begin
                    grid[0][i] = CELL_OFF;
                    grid[1][i] = CELL_OFF;
                end
                n_clears++;
            end
        endcase
        return o;
    endfunction

    task automatic send_cmd(input t_op op, input logic [7:0] col, input logic [7:0] row,
                            input logic [1:0] val, input logic chk, input t_grid_res typed);
        t_grid_res p;
        while ($urandom_range(99) < tx_idle) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid      <= 1'b1;
        cmd.opcode     <= op;
        cmd.cell_col   <= col;
        cmd.cell_row   <= row;
        cmd.cell_value <= val;
        do @(posedge i_clk); while (!cmd.ready);
        p = apply_cmd(op, col, row, val);
        pending_res.push_back(chk ? typed : p);
        n_cmds++;
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cols_reg = w;
        rows_reg = h;
    endtask

    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_grid_res e;
        if (i_rst_n && res.valid && res.ready) begin
            n_res++;
            if (pending_res.size() == 0) begin
                $error("unexpected result transaction");
                fails++;
            end else begin
                e = pending_res.pop_front();
                if (res.cell_state !== e.state) begin
                    $error("cell_state exp %0d got %0d", e.state, res.cell_state);
                    fails++;
                end
                if (res.changed_count !== e.count) begin
                    $error("changed_count exp %0d got %0d", e.count, res.changed_count);
                    fails++;
                end
                if (res.range_error !== e.err) begin
                    $error("range_error exp %0d got %0d", e.err, res.range_error);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    t_row dir_rows [18] = '{
        '{OP_READ,  8'd0,   8'd0,   2'd0, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_WRITE, 8'd255, 8'd0,   2'd2, 1'b1, '{2'd0, 17'd0, 1'b1}},
        '{OP_READ,  8'd0,   8'd255, 2'd0, 1'b1, '{2'd0, 17'd0, 1'b1}},
        '{OP_WRITE, 8'd99,  8'd89,  2'd3, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_READ,  8'd99,  8'd89,  2'd0, 1'b1, '{2'd2, 17'd0, 1'b0}},
        '{OP_WRITE, 8'd100, 8'd89,  2'd2, 1'b1, '{2'd0, 17'd0, 1'b1}},
        '{OP_READ,  8'd99,  8'd90,  2'd0, 1'b1, '{2'd0, 17'd0, 1'b1}},
        '{OP_WRITE, 8'd0,   8'd0,   2'd2, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_WRITE, 8'd1,   8'd0,   2'd2, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_WRITE, 8'd0,   8'd89,  2'd1, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_STEP,  8'd0,   8'd0,   2'd0, 1'b0, '0},
        '{OP_READ,  8'd99,  8'd89,  2'd0, 1'b0, '0},
        '{OP_READ,  8'd0,   8'd89,  2'd0, 1'b0, '0},
        '{OP_STEP,  8'd255, 8'd255, 2'd3, 1'b0, '0},
        '{OP_CLEAR, 8'd0,   8'd0,   2'd0, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_READ,  8'd0,   8'd0,   2'd0, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_READ,  8'd99,  8'd89,  2'd0, 1'b1, '{2'd0, 17'd0, 1'b0}},
        '{OP_WRITE, 8'd0,   8'd0,   2'd0, 1'b1, '{2'd0, 17'd0, 1'b0}}
    };

    logic [DIM_W-1:0] cfg_w [6] = '{9'd0,   9'd511, 9'd1,   9'd7, 9'd16, 9'd3};
    logic [DIM_W-1:0] cfg_h [6] = '{9'd0,   9'd1,   9'd300, 9'd5, 9'd16, 9'd4};

    initial begin
        int unsigned w, h, pick;
        t_op op;
        logic [7:0] c, r;
        cmd.valid      = 1'b0;
        cmd.opcode     = OP_WRITE;
        cmd.cell_col   = '0;
        cmd.cell_row   = '0;
        cmd.cell_value = '0;
        res.ready      = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_WIDTH;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        tx_idle = 0; rx_idle = 0; stall_req = 0; stall_seen = 0; stall_left = 0;
        fails = 0; n_cmds = 0; n_res = 0; n_steps = 0; n_clears = 0; n_oor = 0; quiet = 0;
        for (int i = 0; i < NCELL; i++) begin
            grid[0][i] = CELL_OFF;
            grid[1][i] = CELL_OFF;
        end
        cur_gen  = 1'b0;
        cols_reg = WIDTH_RESET;
        rows_reg = HEIGHT_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle = 16; rx_idle = 76;
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].op, dir_rows[i].col, dir_rows[i].row, dir_rows[i].val,
                     dir_rows[i].chk, dir_rows[i].res);

        for (int p = 0; p < 6; p++) begin
            set_grid(cfg_w[p], cfg_h[p]);
            if (p < 2) begin tx_idle = 16; rx_idle = 76; end
            else if (p < 4) begin tx_idle = 76; rx_idle = 16; end
            else begin tx_idle = 0; rx_idle = 0; end
            if (p == 4) stall_req++;
            w = clamp_dim(cols_reg, MAX_COLS);
            h = clamp_dim(rows_reg, MAX_ROWS);
            for (int k = 0; k < 14; k++) begin
                if (p == 5 && k == 7) drain();
                pick = $urandom_range(99);
                if (pick < 45) op = OP_WRITE;
                else if (pick < 70) op = OP_READ;
                else if (pick < 98 || n_clears > 1) op = OP_STEP;
                else op = OP_CLEAR;
                if ($urandom_range(9) < 8) begin
                    c = 8'($urandom_range(w - 1));
                    r = 8'($urandom_range(h - 1));
                end else begin
                    c = 8'($urandom);
                    r = 8'($urandom);
                end
                send_cmd(op, c, r, ($urandom_range(9) < 6) ? CELL_ON : 2'($urandom),
                         1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("tb: %0d commands, %0d results, %0d steps, %0d clears, %0d out of range",
                 n_cmds, n_res, n_steps, n_clears, n_oor);
        $display("tb: grids from 1x1 to 256-wide and 256-tall, with long receiver stall");
        if (fails == 0 && pending_res.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bbtg_pkg.sv
rtl/bbtg_if.sv
rtl/bbtg_store.sv
rtl/brians_brain_toroidal_grid_core.sv
dv/tb.sv
